// ===== hdl/aqic_pkg.sv =====
// shared types, breakpoint tables and reciprocal constants for the composite air quality index
package aqic_pkg;

   // lanes, one per pollutant
   localparam int LANE_COUNT = 4;
   localparam logic [1:0] LANE_FINE = 2'd0;
   localparam logic [1:0] LANE_COARSE = 2'd1;
   localparam logic [1:0] LANE_CO2 = 2'd2;
   localparam logic [1:0] LANE_VOC = 2'd3;

   // field widths
   localparam int CONC_W = 16;
   localparam int VOC_W = 9;
   localparam int INDEX_W = 13;
   localparam int WEIGHT_W = 10;
   localparam int REG_IDX_W = 8;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_WEIGHT_PM_FINE = 8'd0;
   localparam logic [REG_IDX_W-1:0] REG_WEIGHT_PM_COARSE = 8'd1;
   localparam logic [REG_IDX_W-1:0] REG_WEIGHT_CO2 = 8'd2;
   localparam logic [REG_IDX_W-1:0] REG_WEIGHT_VOC = 8'd3;

   localparam logic [WEIGHT_W-1:0] WEIGHT_PM_FINE_RST = 10'd500;
   localparam logic [WEIGHT_W-1:0] WEIGHT_PM_COARSE_RST = 10'd250;
   localparam logic [WEIGHT_W-1:0] WEIGHT_CO2_RST = 10'd150;
   localparam logic [WEIGHT_W-1:0] WEIGHT_VOC_RST = 10'd100;

   localparam logic [INDEX_W-1:0] INDEX_MAX = 13'd5000;

   // interpolation datapath
   localparam int OFF_W = 13;
   localparam int MUL_W = 10;
   localparam int PROD_W = 21;
   localparam int RECIP_W = 32;
   localparam int RECIP_SHIFT = 32;
   localparam int QPROD_W = PROD_W + RECIP_W;
   localparam logic [63:0] RECIP_NUM = 64'h1_0000_0000;

   // composite datapath
   localparam int WPROD_W = WEIGHT_W + INDEX_W;
   localparam int SUM_W = WPROD_W + 2;
   localparam int COMP_RECIP_W = 26;
   localparam int COMP_SHIFT = 35;
   localparam int COMP_PROD_W = SUM_W + COMP_RECIP_W;
   localparam int COMP_Q_W = COMP_PROD_W - COMP_SHIFT;
   localparam logic [COMP_RECIP_W-1:0] COMP_RECIP =
      26'((64'h8_0000_0000 + 64'd999) / 64'd1000);

   // breakpoint tables
   localparam int SEG_COUNT = 7;
   localparam int SEG_W = 3;

   localparam logic [INDEX_W-1:0] SEG_BASE [SEG_COUNT] =
      '{13'd0, 13'd510, 13'd1010, 13'd1510, 13'd2010, 13'd3010, 13'd4010};
   localparam logic [MUL_W-1:0] SEG_MUL [SEG_COUNT] =
      '{10'd500, 10'd490, 10'd490, 10'd490, 10'd990, 10'd990, 10'd990};

   localparam logic [OFF_W-1:0] FINE_MAX = 13'd5004;
   localparam logic [OFF_W-1:0] FINE_LO [SEG_COUNT] =
      '{13'd0, 13'd121, 13'd355, 13'd555, 13'd1505, 13'd2505, 13'd3505};
   localparam logic [OFF_W-1:0] FINE_HI [SEG_COUNT] =
      '{13'd120, 13'd354, 13'd554, 13'd1504, 13'd2504, 13'd3504, 13'd5004};
   localparam logic [RECIP_W-1:0] FINE_RECIP [SEG_COUNT] = '{
      32'((RECIP_NUM + 64'd119) / 64'd120),
      32'((RECIP_NUM + 64'd232) / 64'd233),
      32'((RECIP_NUM + 64'd198) / 64'd199),
      32'((RECIP_NUM + 64'd948) / 64'd949),
      32'((RECIP_NUM + 64'd998) / 64'd999),
      32'((RECIP_NUM + 64'd998) / 64'd999),
      32'((RECIP_NUM + 64'd1498) / 64'd1499)};

   localparam logic [OFF_W-1:0] COARSE_MAX = 13'd604;
   localparam logic [OFF_W-1:0] COARSE_LO [SEG_COUNT] =
      '{13'd0, 13'd55, 13'd155, 13'd255, 13'd355, 13'd425, 13'd505};
   localparam logic [OFF_W-1:0] COARSE_HI [SEG_COUNT] =
      '{13'd54, 13'd154, 13'd254, 13'd354, 13'd424, 13'd504, 13'd604};
   localparam logic [RECIP_W-1:0] COARSE_RECIP [SEG_COUNT] = '{
      32'((RECIP_NUM + 64'd53) / 64'd54),
      32'((RECIP_NUM + 64'd98) / 64'd99),
      32'((RECIP_NUM + 64'd98) / 64'd99),
      32'((RECIP_NUM + 64'd98) / 64'd99),
      32'((RECIP_NUM + 64'd68) / 64'd69),
      32'((RECIP_NUM + 64'd78) / 64'd79),
      32'((RECIP_NUM + 64'd98) / 64'd99)};

   // co2 ramp, 5000/4600 reduced to 25/23
   localparam logic [CONC_W-1:0] CO2_FLOOR = 16'd400;
   localparam logic [CONC_W-1:0] CO2_CEIL = 16'd5000;
   localparam logic [MUL_W-1:0] CO2_MUL = 10'd25;
   localparam logic [RECIP_W-1:0] CO2_RECIP = 32'((RECIP_NUM + 64'd22) / 64'd23);

   // voc pieces; the steep pieces divide by two exactly
   localparam logic [VOC_W-1:0] VOC_MIN = 9'd1;
   localparam logic [VOC_W-1:0] VOC_MAX = 9'd500;
   localparam logic [VOC_W-1:0] VOC_KNEE_A = 9'd100;
   localparam logic [VOC_W-1:0] VOC_KNEE_B = 9'd250;
   localparam logic [VOC_W-1:0] VOC_KNEE_C = 9'd400;
   localparam logic [INDEX_W-1:0] VOC_BASE_B = 13'd500;
   localparam logic [INDEX_W-1:0] VOC_BASE_C = 13'd1500;
   localparam logic [INDEX_W-1:0] VOC_BASE_D = 13'd3000;
   localparam logic [MUL_W-1:0] VOC_MUL_A = 10'd500;
   localparam logic [MUL_W-1:0] VOC_MUL_B = 10'd1000;
   localparam logic [MUL_W-1:0] VOC_MUL_C = 10'd20;
   localparam logic [MUL_W-1:0] VOC_MUL_D = 10'd40;
   localparam logic [RECIP_W-1:0] VOC_RECIP_A = 32'((RECIP_NUM + 64'd98) / 64'd99);
   localparam logic [RECIP_W-1:0] VOC_RECIP_B = 32'((RECIP_NUM + 64'd149) / 64'd150);
   localparam logic [RECIP_W-1:0] VOC_RECIP_HALF = 32'((RECIP_NUM + 64'd1) / 64'd2);

   typedef struct packed {
      logic [OFF_W-1:0] off;
      logic [INDEX_W-1:0] base;
      logic [MUL_W-1:0] mul;
      logic [RECIP_W-1:0] recip;
   } lane_type;

endpackage

// ===== hdl/aqic_select.sv =====
// first stage: input clamping, segment lookup and per-lane interpolation constants
module aqic_select (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic [aqic_pkg::CONC_W-1:0] pm_fine_tenths,
   input  logic [aqic_pkg::CONC_W-1:0] pm_coarse_ugm3,
   input  logic [aqic_pkg::CONC_W-1:0] carbon_dioxide_ppm,
   input  logic [aqic_pkg::VOC_W-1:0] organic_vapour_level,
   output logic out_valid,
   input  logic out_ready,
   output aqic_pkg::lane_type [aqic_pkg::LANE_COUNT-1:0] lanes
);

   logic vld_ff;
   logic vld_in;
   logic adv;
   aqic_pkg::lane_type [aqic_pkg::LANE_COUNT-1:0] lanes_ff;
   aqic_pkg::lane_type [aqic_pkg::LANE_COUNT-1:0] lanes_in;

   logic [aqic_pkg::OFF_W-1:0] fine_c;
   logic [aqic_pkg::OFF_W-1:0] coarse_c;
   logic [aqic_pkg::CONC_W-1:0] co2_c;
   logic [aqic_pkg::VOC_W-1:0] voc_c;
   logic [aqic_pkg::SEG_W-1:0] fine_seg;
   logic [aqic_pkg::SEG_W-1:0] coarse_seg;

   assign adv = !vld_ff || out_ready;
   assign in_ready = adv;
   assign out_valid = vld_ff;
   assign lanes = lanes_ff;
   assign vld_in = adv ? in_valid : vld_ff;

   always_comb begin
      fine_c = (pm_fine_tenths > aqic_pkg::CONC_W'(aqic_pkg::FINE_MAX)) ?
               aqic_pkg::FINE_MAX : pm_fine_tenths[aqic_pkg::OFF_W-1:0];
      coarse_c = (pm_coarse_ugm3 > aqic_pkg::CONC_W'(aqic_pkg::COARSE_MAX)) ?
                 aqic_pkg::COARSE_MAX : pm_coarse_ugm3[aqic_pkg::OFF_W-1:0];

      // first segment whose upper bound holds the reading
      fine_seg = aqic_pkg::SEG_W'(aqic_pkg::SEG_COUNT - 1);
      coarse_seg = aqic_pkg::SEG_W'(aqic_pkg::SEG_COUNT - 1);
      for (int k = aqic_pkg::SEG_COUNT - 1; k >= 0; k--) begin
         if (fine_c <= aqic_pkg::FINE_HI[k]) begin
            fine_seg = aqic_pkg::SEG_W'(k);
         end
         if (coarse_c <= aqic_pkg::COARSE_HI[k]) begin
            coarse_seg = aqic_pkg::SEG_W'(k);
         end
      end

      lanes_in[aqic_pkg::LANE_FINE].off = fine_c - aqic_pkg::FINE_LO[fine_seg];
      lanes_in[aqic_pkg::LANE_FINE].base = aqic_pkg::SEG_BASE[fine_seg];
      lanes_in[aqic_pkg::LANE_FINE].mul = aqic_pkg::SEG_MUL[fine_seg];
      lanes_in[aqic_pkg::LANE_FINE].recip = aqic_pkg::FINE_RECIP[fine_seg];

      lanes_in[aqic_pkg::LANE_COARSE].off = coarse_c - aqic_pkg::COARSE_LO[coarse_seg];
      lanes_in[aqic_pkg::LANE_COARSE].base = aqic_pkg::SEG_BASE[coarse_seg];
      lanes_in[aqic_pkg::LANE_COARSE].mul = aqic_pkg::SEG_MUL[coarse_seg];
      lanes_in[aqic_pkg::LANE_COARSE].recip = aqic_pkg::COARSE_RECIP[coarse_seg];

      // co2 clamped to the ramp ends gives zero and full scale there
      if (carbon_dioxide_ppm <= aqic_pkg::CO2_FLOOR) begin
         co2_c = aqic_pkg::CO2_FLOOR;
      end else if (carbon_dioxide_ppm >= aqic_pkg::CO2_CEIL) begin
         co2_c = aqic_pkg::CO2_CEIL;
      end else begin
         co2_c = carbon_dioxide_ppm;
      end
      lanes_in[aqic_pkg::LANE_CO2].off = aqic_pkg::OFF_W'(co2_c - aqic_pkg::CO2_FLOOR);
      lanes_in[aqic_pkg::LANE_CO2].base = '0;
      lanes_in[aqic_pkg::LANE_CO2].mul = aqic_pkg::CO2_MUL;
      lanes_in[aqic_pkg::LANE_CO2].recip = aqic_pkg::CO2_RECIP;

      if (organic_vapour_level < aqic_pkg::VOC_MIN) begin
         voc_c = aqic_pkg::VOC_MIN;
      end else if (organic_vapour_level > aqic_pkg::VOC_MAX) begin
         voc_c = aqic_pkg::VOC_MAX;
      end else begin
         voc_c = organic_vapour_level;
      end
      priority if (voc_c <= aqic_pkg::VOC_KNEE_A) begin
         lanes_in[aqic_pkg::LANE_VOC].off = aqic_pkg::OFF_W'(voc_c - aqic_pkg::VOC_MIN);
         lanes_in[aqic_pkg::LANE_VOC].base = '0;
         lanes_in[aqic_pkg::LANE_VOC].mul = aqic_pkg::VOC_MUL_A;
         lanes_in[aqic_pkg::LANE_VOC].recip = aqic_pkg::VOC_RECIP_A;
      end else if (voc_c <= aqic_pkg::VOC_KNEE_B) begin
         lanes_in[aqic_pkg::LANE_VOC].off = aqic_pkg::OFF_W'(voc_c - aqic_pkg::VOC_KNEE_A);
         lanes_in[aqic_pkg::LANE_VOC].base = aqic_pkg::VOC_BASE_B;
         lanes_in[aqic_pkg::LANE_VOC].mul = aqic_pkg::VOC_MUL_B;
         lanes_in[aqic_pkg::LANE_VOC].recip = aqic_pkg::VOC_RECIP_B;
      end else if (voc_c <= aqic_pkg::VOC_KNEE_C) begin
         lanes_in[aqic_pkg::LANE_VOC].off = aqic_pkg::OFF_W'(voc_c - aqic_pkg::VOC_KNEE_B);
         lanes_in[aqic_pkg::LANE_VOC].base = aqic_pkg::VOC_BASE_C;
         lanes_in[aqic_pkg::LANE_VOC].mul = aqic_pkg::VOC_MUL_C;
         lanes_in[aqic_pkg::LANE_VOC].recip = aqic_pkg::VOC_RECIP_HALF;
      end else begin
         lanes_in[aqic_pkg::LANE_VOC].off = aqic_pkg::OFF_W'(voc_c - aqic_pkg::VOC_KNEE_C);
         lanes_in[aqic_pkg::LANE_VOC].base = aqic_pkg::VOC_BASE_D;
         lanes_in[aqic_pkg::LANE_VOC].mul = aqic_pkg::VOC_MUL_D;
         lanes_in[aqic_pkg::LANE_VOC].recip = aqic_pkg::VOC_RECIP_HALF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lanes_ff <= lanes_in;
      end
   end

endmodule

// ===== hdl/aqic_interp.sv =====
// three-stage interpolation of all four lanes: scale, reciprocal divide, add base
module aqic_interp (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  aqic_pkg::lane_type [aqic_pkg::LANE_COUNT-1:0] lanes,
   output logic out_valid,
   input  logic out_ready,
   output logic [aqic_pkg::LANE_COUNT-1:0][aqic_pkg::INDEX_W-1:0] sub_index
);

   localparam int STAGES = 3;

   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] vld_in;
   logic [STAGES-1:0] adv;

   // stage a: scaled offset
   logic [aqic_pkg::LANE_COUNT-1:0][aqic_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [aqic_pkg::LANE_COUNT-1:0][aqic_pkg::RECIP_W-1:0] recip_ff;
   logic [aqic_pkg::LANE_COUNT-1:0][aqic_pkg::INDEX_W-1:0] base_a_ff;
   // stage b: quotient
   logic [aqic_pkg::LANE_COUNT-1:0][aqic_pkg::PROD_W-1:0] quot_ff, quot_in;
   logic [aqic_pkg::LANE_COUNT-1:0][aqic_pkg::INDEX_W-1:0] base_b_ff;
   // stage c: sub-index
   logic [aqic_pkg::LANE_COUNT-1:0][aqic_pkg::INDEX_W-1:0] idx_ff, idx_in;

   logic [aqic_pkg::OFF_W+aqic_pkg::MUL_W-1:0] scaled;
   logic [aqic_pkg::QPROD_W-1:0] qprod;

   assign adv[2] = !vld_ff[2] || out_ready;
   assign adv[1] = !vld_ff[1] || adv[2];
   assign adv[0] = !vld_ff[0] || adv[1];
   assign in_ready = adv[0];
   assign out_valid = vld_ff[2];
   assign sub_index = idx_ff;

   assign vld_in[0] = adv[0] ? in_valid : vld_ff[0];
   assign vld_in[1] = adv[1] ? vld_ff[0] : vld_ff[1];
   assign vld_in[2] = adv[2] ? vld_ff[1] : vld_ff[2];

   always_comb begin
      scaled = '0;
      qprod = '0;
      for (int k = 0; k < aqic_pkg::LANE_COUNT; k++) begin
         scaled = lanes[k].off * lanes[k].mul;
         prod_in[k] = scaled[aqic_pkg::PROD_W-1:0];
         // exact floor division by the segment span
         qprod = prod_ff[k] * recip_ff[k];
         quot_in[k] = qprod[aqic_pkg::QPROD_W-1:aqic_pkg::RECIP_SHIFT];
         idx_in[k] = base_b_ff[k] + quot_ff[k][aqic_pkg::INDEX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         prod_ff <= prod_in;
         for (int k = 0; k < aqic_pkg::LANE_COUNT; k++) begin
            recip_ff[k] <= lanes[k].recip;
            base_a_ff[k] <= lanes[k].base;
         end
      end
      if (adv[1]) begin
         quot_ff <= quot_in;
         base_b_ff <= base_a_ff;
      end
      if (adv[2]) begin
         idx_ff <= idx_in;
      end
   end

endmodule

// ===== hdl/aqic_blend.sv =====
// four-stage weighted composite: weight products, sum, divide by 1000, clamp
module aqic_blend (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic [aqic_pkg::LANE_COUNT-1:0][aqic_pkg::INDEX_W-1:0] sub_index,
   input  logic [aqic_pkg::LANE_COUNT-1:0][aqic_pkg::WEIGHT_W-1:0] weight,
   output logic out_valid,
   input  logic out_ready,
   output logic [aqic_pkg::LANE_COUNT-1:0][aqic_pkg::INDEX_W-1:0] index_lane,
   output logic [aqic_pkg::INDEX_W-1:0] index_composite
);

   localparam int STAGES = 4;

   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] vld_in;
   logic [STAGES-1:0] adv;

   logic [aqic_pkg::LANE_COUNT-1:0][aqic_pkg::WPROD_W-1:0] wprod_ff, wprod_in;
   logic [aqic_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [aqic_pkg::COMP_Q_W-1:0] quot_ff, quot_in;
   logic [aqic_pkg::INDEX_W-1:0] comp_ff, comp_in;
   logic [aqic_pkg::COMP_PROD_W-1:0] cprod;

   // sub-indices ride alongside the composite
   logic [STAGES-1:0][aqic_pkg::LANE_COUNT-1:0][aqic_pkg::INDEX_W-1:0] lane_ff;

   assign adv[3] = !vld_ff[3] || out_ready;
   assign adv[2] = !vld_ff[2] || adv[3];
   assign adv[1] = !vld_ff[1] || adv[2];
   assign adv[0] = !vld_ff[0] || adv[1];
   assign in_ready = adv[0];
   assign out_valid = vld_ff[3];
   assign index_lane = lane_ff[3];
   assign index_composite = comp_ff;

   assign vld_in[0] = adv[0] ? in_valid : vld_ff[0];
   assign vld_in[1] = adv[1] ? vld_ff[0] : vld_ff[1];
   assign vld_in[2] = adv[2] ? vld_ff[1] : vld_ff[2];
   assign vld_in[3] = adv[3] ? vld_ff[2] : vld_ff[3];

   always_comb begin
      for (int k = 0; k < aqic_pkg::LANE_COUNT; k++) begin
         wprod_in[k] = weight[k] * sub_index[k];
      end
      sum_in = aqic_pkg::SUM_W'(wprod_ff[0]) + aqic_pkg::SUM_W'(wprod_ff[1])
             + aqic_pkg::SUM_W'(wprod_ff[2]) + aqic_pkg::SUM_W'(wprod_ff[3]);
      // exact floor division by 1000
      cprod = sum_ff * aqic_pkg::COMP_RECIP;
      quot_in = cprod[aqic_pkg::COMP_PROD_W-1:aqic_pkg::COMP_SHIFT];
      comp_in = (quot_ff > aqic_pkg::COMP_Q_W'(aqic_pkg::INDEX_MAX)) ?
                aqic_pkg::INDEX_MAX : quot_ff[aqic_pkg::INDEX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         wprod_ff <= wprod_in;
         lane_ff[0] <= sub_index;
      end
      if (adv[1]) begin
         sum_ff <= sum_in;
         lane_ff[1] <= lane_ff[0];
      end
      if (adv[2]) begin
         quot_ff <= quot_in;
         lane_ff[2] <= lane_ff[1];
      end
      if (adv[3]) begin
         comp_ff <= comp_in;
         lane_ff[3] <= lane_ff[2];
      end
   end

endmodule

// ===== hdl/air_quality_index_composite_top.sv =====
// top level of the composite air quality index pipeline
//
// req_ carries one reading per item (pm2.5, pm10, co2, voc); rsp_ returns the
// four sub-indices and the weighted composite, all in tenths of a point.
// csr_ writes the four composite weights (index 0..3, thousandths); any other
// index is dropped. csr_ready is always high; weights should only change while
// no item is in flight.
// the datapath is an eight-stage pipeline: one stage of clamping and segment
// lookup, three of interpolation (scale, reciprocal multiply, add base) and
// four for the composite (weight products, sum, divide by 1000, clamp).
// the first stage loads at the accepting edge, and one item is taken every cycle
// while rsp_ is not stalled; the reciprocal multipliers set the stage depth.
// every stage has its own valid bit and hand-off, so a stall on rsp_ fills
// empty stages first and only then deasserts req_tready; nothing is lost or
// repeated. reset empties the pipeline and loads the default weights
// (500, 250, 150, 100).
module air_quality_index_composite_top (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // pm_fine_tenths[15:0], pm_coarse_ugm3[31:16], carbon_dioxide_ppm[47:32],
   // organic_vapour_level[56:48], zero fill [63:57]
   input  logic [63:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // index_pm_fine[12:0], index_pm_coarse[25:13], index_carbon_dioxide[38:26],
   // index_organic_vapour[51:39], index_composite[64:52], zero fill [71:65]
   output logic [71:0] rsp_tdata,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [aqic_pkg::REG_IDX_W-1:0] csr_index,
   input  logic [aqic_pkg::WEIGHT_W-1:0] csr_wdata
);

   logic [aqic_pkg::LANE_COUNT-1:0][aqic_pkg::WEIGHT_W-1:0] weight_ff;
   logic [aqic_pkg::LANE_COUNT-1:0][aqic_pkg::WEIGHT_W-1:0] weight_in;

   logic sel_valid, sel_ready;
   aqic_pkg::lane_type [aqic_pkg::LANE_COUNT-1:0] sel_lanes;
   logic int_valid, int_ready;
   logic [aqic_pkg::LANE_COUNT-1:0][aqic_pkg::INDEX_W-1:0] int_index;
   logic [aqic_pkg::LANE_COUNT-1:0][aqic_pkg::INDEX_W-1:0] out_index;
   logic [aqic_pkg::INDEX_W-1:0] out_composite;

   assign csr_ready = 1'b1;

   always_comb begin
      weight_in = weight_ff;
      if (csr_valid) begin
         unique case (csr_index)
            aqic_pkg::REG_WEIGHT_PM_FINE: weight_in[aqic_pkg::LANE_FINE] = csr_wdata;
            aqic_pkg::REG_WEIGHT_PM_COARSE: weight_in[aqic_pkg::LANE_COARSE] = csr_wdata;
            aqic_pkg::REG_WEIGHT_CO2: weight_in[aqic_pkg::LANE_CO2] = csr_wdata;
            aqic_pkg::REG_WEIGHT_VOC: weight_in[aqic_pkg::LANE_VOC] = csr_wdata;
            default: weight_in = weight_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff[aqic_pkg::LANE_FINE] <= aqic_pkg::WEIGHT_PM_FINE_RST;
         weight_ff[aqic_pkg::LANE_COARSE] <= aqic_pkg::WEIGHT_PM_COARSE_RST;
         weight_ff[aqic_pkg::LANE_CO2] <= aqic_pkg::WEIGHT_CO2_RST;
         weight_ff[aqic_pkg::LANE_VOC] <= aqic_pkg::WEIGHT_VOC_RST;
      end else begin
         weight_ff <= weight_in;
      end
   end

   aqic_select u_select (
      .clock                (clock),
      .reset                (reset),
      .in_valid             (req_tvalid),
      .in_ready             (req_tready),
      .pm_fine_tenths       (req_tdata[15:0]),
      .pm_coarse_ugm3       (req_tdata[31:16]),
      .carbon_dioxide_ppm   (req_tdata[47:32]),
      .organic_vapour_level (req_tdata[56:48]),
      .out_valid            (sel_valid),
      .out_ready            (sel_ready),
      .lanes                (sel_lanes)
   );

   aqic_interp u_interp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sel_valid),
      .in_ready  (sel_ready),
      .lanes     (sel_lanes),
      .out_valid (int_valid),
      .out_ready (int_ready),
      .sub_index (int_index)
   );

   aqic_blend u_blend (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (int_valid),
      .in_ready        (int_ready),
      .sub_index       (int_index),
      .weight          (weight_ff),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .index_lane      (out_index),
      .index_composite (out_composite)
   );

   assign rsp_tdata = {7'd0,
                       out_composite,
                       out_index[aqic_pkg::LANE_VOC],
                       out_index[aqic_pkg::LANE_CO2],
                       out_index[aqic_pkg::LANE_COARSE],
                       out_index[aqic_pkg::LANE_FINE]};

endmodule
